// ----- rtl/sqd_pkg.sv -----
// ----------------------------------------------------------------------------
// Shortest-queue dispatcher package
// Shared types, codes and constants for the dispatcher front, queue and back.
// ----------------------------------------------------------------------------
package sqd_pkg;

    localparam int unsigned NUM_QUEUES          = 4;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 64;
    localparam int unsigned QSEL_W              = 2;

    localparam logic [15:0] CLOSE_TIME_RESET = 16'd50;

    // Event commands.
    localparam logic CMD_ARRIVAL   = 1'b0;
    localparam logic CMD_DEPARTURE = 1'b1;

    // Error codes.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // What the front decided an event is.
    typedef enum logic [1:0] {
        K_ARRIVE = 2'd0,
        K_CLOSED = 2'd1,
        K_DEPART = 2'd2
    } kind_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] event_time;
        logic [1:0]  queue_index;
        logic [4:0]  service_duration;
        logic [2:0]  arrival_gap;
    } evt_t;

    typedef struct packed {
        logic        next_arrival_valid;
        logic [15:0] next_arrival_time;
        logic        departure_valid;
        logic [15:0] departure_time;
        logic [1:0]  departure_queue;
        logic [31:0] total_wait;
        logic [15:0] customer_count;
        logic [1:0]  error_code;
    } res_t;

    // Classified work item handed from the front to the back.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] event_time;
        logic [1:0]  queue_index;
        logic [4:0]  service_duration;
        logic [15:0] next_time;
    } work_t;

    // One FIFO slot: arrival stamp and service time of a waiting customer.
    typedef struct packed {
        logic [15:0] stamp;
        logic [4:0]  service;
    } slot_t;

endpackage

// ----- rtl/sqd_front.sv -----
// ----------------------------------------------------------------------------
// Dispatcher front
// Holds close_time, accepts event beats and classifies each one.
// ----------------------------------------------------------------------------
module sqd_front
    import sqd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        evt_valid,
    output logic        evt_ready,
    input  evt_t        evt,
    input  logic        q_full,
    output logic        push,
    output work_t       push_data
);

    logic [15:0] close_time_reg;
    logic [16:0] next_sum;
    logic        admit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_time_reg <= CLOSE_TIME_RESET;
        end
        else if (cfg_we)
        begin
            close_time_reg <= cfg_wdata;
        end
    end

    // The sum keeps its carry, so a wrapped time is never admitted.
    assign next_sum  = {1'b0, evt.event_time} + 17'(evt.arrival_gap);
    assign admit     = next_sum < {1'b0, close_time_reg};
    assign evt_ready = !q_full;
    assign push      = evt_valid && !q_full;

    always_comb
    begin
        push_data.event_time       = evt.event_time;
        push_data.queue_index      = evt.queue_index;
        push_data.service_duration = evt.service_duration;
        push_data.next_time        = next_sum[15:0];
        if (evt.cmd == CMD_DEPARTURE)
        begin
            push_data.kind = K_DEPART;
        end
        else if (admit)
        begin
            push_data.kind = K_ARRIVE;
        end
        else
        begin
            push_data.kind = K_CLOSED;
        end
    end

endmodule

// ----- rtl/sqd_queue.sv -----
// ----------------------------------------------------------------------------
// Dispatcher work queue
// Two-entry FIFO of classified work items between the front and the back.
// ----------------------------------------------------------------------------
module sqd_queue
    import sqd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output work_t pop_data
);

    localparam int unsigned QDEPTH = 2;

    work_t       mem_reg [QDEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full     = count_reg == 2'(QDEPTH);
    assign empty    = count_reg == 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/sqd_back.sv -----
// ----------------------------------------------------------------------------
// Dispatcher back
// Executes work items against the four FIFO queues and registers results.
// ----------------------------------------------------------------------------
module sqd_back
    import sqd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_empty,
    input  work_t q_data,
    output logic  pop,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    localparam int unsigned SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int unsigned SLOT_W = $clog2(SLOTS);
    localparam int unsigned POS_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TAIL_W = CNT_W + 1;
    localparam logic [POS_W-1:0]  HEAD_LAST = POS_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [TAIL_W-1:0] TAIL_WRAP = TAIL_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    work_t            cur_reg, cur_next;
    logic [POS_W-1:0] head_reg  [NUM_QUEUES];
    logic [POS_W-1:0] head_next [NUM_QUEUES];
    logic [CNT_W-1:0] count_reg [NUM_QUEUES];
    logic [CNT_W-1:0] count_next[NUM_QUEUES];
    logic [31:0]      wait_reg, wait_next;
    logic [15:0]      seen_reg, seen_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    slot_t             mem [SLOTS];
    slot_t             rd_a_reg, rd_b_reg;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    slot_t             wr_data;

    logic [QSEL_W-1:0] best_q;
    logic [CNT_W-1:0]  best_cnt;
    logic [TAIL_W-1:0] tail_sum;
    logic [POS_W-1:0]  tail_pos;
    logic [POS_W-1:0]  dq_head, dq_head_inc, cur_head_inc;
    logic [QSEL_W-1:0] cur_q;
    logic [15:0]       spent;
    logic [32:0]       wait_sum;
    logic              out_free;

    // Lowest-numbered queue among those with the fewest customers.
    always_comb
    begin
        best_q   = '0;
        best_cnt = count_reg[0];
        for (int k = 1; k < NUM_QUEUES; k++)
        begin
            if (count_reg[k] < best_cnt)
            begin
                best_q   = QSEL_W'(k);
                best_cnt = count_reg[k];
            end
        end
    end

    assign tail_sum = TAIL_W'(head_reg[best_q]) + TAIL_W'(best_cnt);
    assign tail_pos = (tail_sum >= TAIL_WRAP) ? POS_W'(tail_sum - TAIL_WRAP)
                                              : POS_W'(tail_sum);

    assign dq_head      = head_reg[q_data.queue_index];
    assign dq_head_inc  = (dq_head == HEAD_LAST) ? '0 : dq_head + POS_W'(1);
    assign cur_q        = cur_reg.queue_index;
    assign cur_head_inc = (head_reg[cur_q] == HEAD_LAST) ? '0
                                                         : head_reg[cur_q] + POS_W'(1);

    assign rd_addr_a = SLOT_W'(q_data.queue_index) * SLOT_W'(QUEUE_DEPTH)
                     + SLOT_W'(dq_head);
    assign rd_addr_b = SLOT_W'(q_data.queue_index) * SLOT_W'(QUEUE_DEPTH)
                     + SLOT_W'(dq_head_inc);
    assign wr_addr   = SLOT_W'(best_q) * SLOT_W'(QUEUE_DEPTH) + SLOT_W'(tail_pos);
    assign wr_data   = '{stamp: q_data.event_time, service: q_data.service_duration};

    assign spent    = cur_reg.event_time - rd_a_reg.stamp;
    assign wait_sum = {1'b0, wait_reg} + 33'(spent);

    assign out_free = !res_valid_reg || res_ready;
    assign pop      = (state_reg == ST_IDLE) && !q_empty && out_free;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        wait_next      = wait_reg;
        seen_next      = seen_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    res_next            = '0;
                    res_next.total_wait = wait_reg;
                    if (q_data.kind != K_DEPART && seen_reg != 16'hFFFF)
                    begin
                        seen_next = seen_reg + 16'd1;
                    end
                    res_next.customer_count = seen_next;
                    unique case (q_data.kind)
                        K_ARRIVE:
                        begin
                            res_next.next_arrival_valid = 1'b1;
                            res_next.next_arrival_time  = q_data.next_time;
                            res_next.departure_queue    = best_q;
                            res_valid_next              = 1'b1;
                            if (best_cnt == CNT_FULL)
                            begin
                                res_next.error_code = ERR_FULL;
                            end
                            else
                            begin
                                wr_en              = 1'b1;
                                count_next[best_q] = best_cnt + CNT_W'(1);
                                if (best_cnt == '0)
                                begin
                                    res_next.departure_valid = 1'b1;
                                    res_next.departure_time  =
                                        q_data.event_time + 16'(q_data.service_duration);
                                end
                            end
                        end
                        K_CLOSED:
                        begin
                            res_valid_next = 1'b1;
                        end
                        K_DEPART:
                        begin
                            if (count_reg[q_data.queue_index] == '0)
                            begin
                                res_next.departure_queue = q_data.queue_index;
                                res_next.error_code      = ERR_EMPTY;
                                res_valid_next           = 1'b1;
                            end
                            else
                            begin
                                cur_next   = q_data;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // The head slot and the one behind it were read at the pop edge.
                wait_next         = wait_sum[32] ? 32'hFFFF_FFFF : wait_sum[31:0];
                head_next[cur_q]  = cur_head_inc;
                count_next[cur_q] = count_reg[cur_q] - CNT_W'(1);
                res_next                 = '0;
                res_next.departure_queue = cur_q;
                res_next.total_wait      = wait_next;
                res_next.customer_count  = seen_reg;
                if (count_reg[cur_q] != CNT_W'(1))
                begin
                    res_next.departure_valid = 1'b1;
                    res_next.departure_time  = cur_reg.event_time + 16'(rd_b_reg.service);
                end
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= '0;
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_QUEUES; k++)
            begin
                head_reg[k]  <= '0;
                count_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/shortest_queue_dispatcher_top.sv -----
// ----------------------------------------------------------------------------
// Shortest-queue dispatcher
// Join-shortest-queue dispatcher over four FIFO service queues.
// ----------------------------------------------------------------------------
// Usage:
// Events come in on the evt channel (valid/ready), one beat per arrival or
// departure taken from an outside time-ordered event list. Each event beat
// produces exactly one result beat on the res channel (valid/ready), in order.
// The close_time register is written through cfg_we/cfg_wdata with no wait;
// write it only while no event is in flight.
// The back executes an arrival or an empty-queue departure in ST_IDLE, and a
// departure that pops a customer in ST_IDLE and then ST_READ, set by the
// registered read of the customer memory; each result is registered.
// The back takes one arrival per cycle while the result receiver is ready,
// and takes no new work item while a departure is in ST_READ.
// The front takes a new beat whenever the two-entry work queue has room, so
// it keeps accepting while a result waits in the output register. When the
// receiver stalls, the result holds, the back stops and the queue fills,
// after which evt_ready drops.
// Reset clears the queue counts and heads, the totals and close_time (to 50);
// the customer memory is not cleared, since only written slots are read.
// ----------------------------------------------------------------------------
module shortest_queue_dispatcher_top
    import sqd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        evt_valid,
    output logic        evt_ready,
    input  evt_t        evt,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    work_t push_data;
    work_t pop_data;

    // The front classifies each beat against close_time.
    sqd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // A short queue lets front and back stall independently.
    sqd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    // The back owns the queue state and the customer memory.
    sqd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ----- rtl/sqd_checker.sv -----
// ----------------------------------------------------------------------------
// Dispatcher port checker
// Checks result beats at the top-level ports for consistent codes and flags.
// ----------------------------------------------------------------------------
module sqd_checker
    import sqd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // A departure from an empty queue schedules nothing.
    a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error_code == ERR_EMPTY
        |-> !res.next_arrival_valid && !res.departure_valid)
        else $error("empty-queue departure scheduled an event");

    // A full queue still schedules the next arrival but no departure.
    a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error_code == ERR_FULL
        |-> res.next_arrival_valid && !res.departure_valid)
        else $error("full-queue result has wrong valid flags");

    // Times are zero when their valid flag is low.
    a_zero_times: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid
        |-> (res.departure_valid || res.departure_time == 16'd0)
            && (res.next_arrival_valid || res.next_arrival_time == 16'd0))
        else $error("time field set without its valid flag");

    // A stalled result beat holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

endmodule

bind shortest_queue_dispatcher_top sqd_checker u_sqd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
